// ----- design/bbd_pkg.sv -----
// Shared types, constants and helper functions of the Bayer demosaic unit.
package bbd_pkg;

  // Field and register widths of the external ports and of the row count
  localparam int RAW_W       = 16;
  localparam int RGB_W       = 18;
  localparam int SIZE_W      = 13;
  localparam int ROW_W       = 12;
  localparam int CFG_IDX_W   = 1;

  // Defaults and limits
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_SIZE       = 3;
  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(480);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Colour of a mosaic site
  typedef enum logic [1:0] {
    COL_RED,
    COL_GREEN,
    COL_BLUE
  } colour_t;

  // Kernel weight of a window tap, already scaled by four
  typedef logic [2:0] weight_t;

  // GBRG: G/B on even rows, R/G on odd rows
  function automatic colour_t site_colour(input logic xpar, input logic ypar);
    colour_t col;
    if (!ypar) col = xpar ? COL_BLUE : COL_GREEN;
    else       col = xpar ? COL_GREEN : COL_RED;
    return col;
  endfunction

  // R and B: corners 1, edges 2, centre 4. G: corners 0, arms 1, centre 4.
  function automatic weight_t kernel_weight(input colour_t col, input logic [1:0] r,
                                            input logic [1:0] c);
    logic    r_mid;
    logic    c_mid;
    weight_t wt;
    r_mid = (r == 2'd1);
    c_mid = (c == 2'd1);
    if (r_mid && c_mid)       wt = 3'd4;
    else if (r_mid || c_mid)  wt = (col == COL_GREEN) ? 3'd1 : 3'd2;
    else                      wt = (col == COL_GREEN) ? 3'd0 : 3'd1;
    return wt;
  endfunction

  // One result item as held in the output queue
  typedef struct packed {
    logic [RGB_W-1:0] red;
    logic [RGB_W-1:0] green;
    logic [RGB_W-1:0] blue;
    logic             last;
  } result_t;

endpackage

// ----- design/bbd_pix_if.sv -----
// Raw pixel stream channel: valid, ready and one mosaic sample.
interface bbd_pix_if
  import bbd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sample;
  logic             frame_start;

  modport source (output valid, output raw_sample, output frame_start, input ready);
  modport sink   (input valid, input raw_sample, input frame_start, output ready);
endinterface

// ----- design/bbd_rgb_if.sv -----
// RGB result stream channel: valid, ready and one interpolated pixel.
interface bbd_rgb_if
  import bbd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RGB_W-1:0] red_out;
  logic [RGB_W-1:0] green_out;
  logic [RGB_W-1:0] blue_out;
  logic             frame_last;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_last, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input frame_last, output ready);
endinterface

// ----- design/bayer_bilinear_demosaic_unit.sv -----
// Streaming 3x3 bilinear demosaic of a GBRG mosaic with a shared line memory.
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+-------------------------------------------
//  pix_in    | in  | valid/ready  | raw_sample[15:0], frame_start
//  rgb_out   | out | valid/ready  | red_out, green_out, blue_out [17:0], frame_last
//  cfg       | in  | cfg_we       | cfg_index (0 width, 1 height), cfg_data[12:0]
//
//  One pixel per cycle while the input is not held (clearing pass, full queue); a result
//  passes the line memory read, then the window and kernel sums, into a three-entry output queue.
//  The line memory is one port pair of 2*PIXEL_BITS bits by MAX_WIDTH entries.
//  After reset a clearing pass zeroes every line memory entry; no pixel is taken
//  meanwhile. Configuration writes are taken at any time.
//  pix_in.ready depends on registers only; a stalled output fills the queue and then
//  holds the input.
module bayer_bilinear_demosaic_unit
  import bbd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  bbd_pix_if.sink              pix_in,
  bbd_rgb_if.source            rgb_out
);

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W  = (CW + 1 > SIZE_W + 1) ? CW + 1 : SIZE_W + 1;
  localparam int ACC_W  = PIXEL_BITS + 4;
  localparam int LINE_W = 2 * PIXEL_BITS;
  localparam int Q_DEPTH = 3;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // Configuration registers
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;

  // Position of the next pixel
  logic [CW-1:0]    column_count;
  logic [ROW_W-1:0] row_count;

  // Line memory clearing pass
  logic          clr_active;
  logic [CW-1:0] clr_addr;

  // Line memory: upper half is row y-2, lower half is row y-1
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_data;
  logic [LINE_W-1:0] fwd_data;
  logic              fwd;

  // Window stage
  logic          s1_valid;
  logic          s1_emit;
  logic          s1_last;
  logic          s1_xpar;
  logic          s1_ypar;
  logic [CW-1:0] s1_addr;
  pix_t          s1_s;
  pix_t          window_regs [6];

  // Output queue
  result_t     queue [Q_DEPTH];
  logic [1:0]  q_wr;
  logic [1:0]  q_rd;
  logic [1:0]  q_count;

  // Accept stage signals
  logic              in_accept;
  logic [CMP_W-1:0]  w_ext;
  logic [CMP_W-1:0]  h_ext;
  logic [CMP_W-1:0]  col_base;
  logic [CMP_W-1:0]  row_base;
  logic [CMP_W-1:0]  cx;
  logic [CMP_W-1:0]  cy;
  logic [CMP_W-1:0]  row_step;
  logic [CMP_W-1:0]  cx_inc;
  logic [CMP_W-1:0]  cy_inc;
  logic [CMP_W-1:0]  col_next;
  logic [CMP_W-1:0]  row_next;
  pix_t              s0;
  logic              s0_emit;
  logic              s0_last;

  // Window stage signals
  pix_t              top;
  pix_t              mid;
  pix_t              win [3][3];
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_g;
  logic [ACC_W-1:0]  acc_b;
  logic [ACC_W-1:0]  term;
  colour_t           tap_col;
  weight_t           tap_wt;
  logic              push;
  logic              pop;
  logic [2:0]        pending;

  // Clamp a size write to its legal range
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int hi);
    logic [SIZE_W-1:0] r;
    if (32'(v) < 32'(MIN_SIZE))  r = SIZE_W'(MIN_SIZE);
    else if (32'(v) > 32'(hi))   r = SIZE_W'(hi);
    else                         r = v;
    return r;
  endfunction

  // Position, sample masking, result flags and next position of the arriving pixel
  always_comb begin
    w_ext    = CMP_W'(frame_width);
    h_ext    = CMP_W'(frame_height);
    col_base = pix_in.frame_start ? '0 : CMP_W'(column_count);
    row_base = pix_in.frame_start ? '0 : CMP_W'(row_count);
    if (col_base >= w_ext) begin
      cx       = '0;
      row_step = row_base + CMP_W'(1);
    end else begin
      cx       = col_base;
      row_step = row_base;
    end
    cy = (row_step >= h_ext) ? '0 : row_step;

    s0 = pix_in.raw_sample[PIXEL_BITS-1:0];
    if (cx >= {w_ext[CMP_W-1:1], 1'b0} || cy >= {h_ext[CMP_W-1:1], 1'b0}) begin
      s0 = '0;
    end
    s0_emit = (cx >= CMP_W'(2)) && (cy >= CMP_W'(2));
    s0_last = (cx == w_ext - CMP_W'(1)) && (cy == h_ext - CMP_W'(1));

    cx_inc = cx + CMP_W'(1);
    cy_inc = cy + CMP_W'(1);
    if (cx_inc >= w_ext) begin
      col_next = '0;
      row_next = (cy_inc >= h_ext) ? '0 : cy_inc;
    end else begin
      col_next = cx_inc;
      row_next = cy;
    end
  end

  // Credit for the output queue: room for everything already in flight
  assign pending       = {1'b0, q_count} + {2'b00, (s1_valid && s1_emit)};
  assign pix_in.ready  = !clr_active && (pending <= 3'(Q_DEPTH - 1));
  assign in_accept     = pix_in.valid && pix_in.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= clamp_size(cfg_data, MAX_WIDTH);
        REG_FRAME_HEIGHT: frame_height <= clamp_size(cfg_data, MAX_HEIGHT);
      endcase
    end
  end

  // Advance the position counts and run the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      clr_active   <= 1'b1;
      clr_addr     <= '0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + CW'(1);
        if (clr_addr == CW'(MAX_WIDTH - 1)) clr_active <= 1'b0;
      end
      if (in_accept) begin
        column_count <= col_next[CW-1:0];
        row_count    <= row_next[ROW_W-1:0];
      end
    end
  end

  // Line memory: read at accept, write back from the window stage
  always_ff @(posedge clk) begin
    if (in_accept) rd_data <= line_mem[cx[CW-1:0]];
    if (clr_active) begin
      line_mem[clr_addr] <= '0;
    end else if (s1_valid) begin
      line_mem[s1_addr] <= {mid, s1_s};
    end
  end

  // Hold the accepted pixel for the window stage; forward a same-entry write
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
    if (in_accept) begin
      s1_addr  <= cx[CW-1:0];
      s1_s     <= s0;
      s1_emit  <= s0_emit;
      s1_last  <= s0_last;
      s1_xpar  <= cx[0];
      s1_ypar  <= cy[0];
      fwd      <= s1_valid && (s1_addr == cx[CW-1:0]);
      fwd_data <= {mid, s1_s};
    end
  end

  // Line memory data with the forwarded entry taking precedence
  assign top = fwd ? fwd_data[LINE_W-1:PIXEL_BITS] : rd_data[LINE_W-1:PIXEL_BITS];
  assign mid = fwd ? fwd_data[PIXEL_BITS-1:0]      : rd_data[PIXEL_BITS-1:0];

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) window_regs[i] <= '0;
    end else if (s1_valid) begin
      window_regs[0] <= window_regs[3];
      window_regs[1] <= window_regs[4];
      window_regs[2] <= window_regs[5];
      window_regs[3] <= top;
      window_regs[4] <= mid;
      window_regs[5] <= s1_s;
    end
  end

  // Assemble the 3x3 window, win[row][col]
  always_comb begin
    win[0][0] = window_regs[0];
    win[1][0] = window_regs[1];
    win[2][0] = window_regs[2];
    win[0][1] = window_regs[3];
    win[1][1] = window_regs[4];
    win[2][1] = window_regs[5];
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = s1_s;
  end

  // Kernel sums: each tap goes to its site colour with weight 0, 1, 2 or 4
  always_comb begin
    acc_r   = '0;
    acc_g   = '0;
    acc_b   = '0;
    term    = '0;
    tap_col = COL_GREEN;
    tap_wt  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        tap_col = site_colour(s1_xpar ^ c[0], s1_ypar ^ r[0]);
        tap_wt  = kernel_weight(tap_col, 2'(r), 2'(c));
        unique case (tap_wt)
          3'd1:    term = ACC_W'(win[r][c]);
          3'd2:    term = ACC_W'(win[r][c]) << 1;
          3'd4:    term = ACC_W'(win[r][c]) << 2;
          default: term = '0;
        endcase
        unique case (tap_col)
          COL_RED:   acc_r = acc_r + term;
          COL_GREEN: acc_g = acc_g + term;
          COL_BLUE:  acc_b = acc_b + term;
          default:   acc_g = acc_g;
        endcase
      end
    end
  end

  // Output queue
  assign push = s1_valid && s1_emit;
  assign pop  = rgb_out.valid && rgb_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (push) q_wr <= (q_wr == 2'(Q_DEPTH - 1)) ? '0 : q_wr + 2'd1;
      if (pop)  q_rd <= (q_rd == 2'(Q_DEPTH - 1)) ? '0 : q_rd + 2'd1;
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      queue[q_wr].red   <= RGB_W'(acc_r);
      queue[q_wr].green <= RGB_W'(acc_g);
      queue[q_wr].blue  <= RGB_W'(acc_b);
      queue[q_wr].last  <= s1_last;
    end
  end

  assign rgb_out.valid      = (q_count != 2'd0);
  assign rgb_out.red_out    = queue[q_rd].red;
  assign rgb_out.green_out  = queue[q_rd].green;
  assign rgb_out.blue_out   = queue[q_rd].blue;
  assign rgb_out.frame_last = queue[q_rd].last;

endmodule

// ----- design/bbd_checker.sv -----
// Port-level checks of the demosaic unit, bound to its top level.
module bbd_checker
  import bbd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [RGB_W-1:0] red_out,
  input logic [RGB_W-1:0] green_out,
  input logic [RGB_W-1:0] blue_out,
  input logic             frame_last
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out) && $stable(frame_last))
    else $error("stalled result item changed or dropped");

  // No pixel is taken right after reset while the line memory is cleared
  a_clear_after_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready)
    else $error("pixel taken during line memory clearing");

  // A result only appears after a pixel is taken and has passed the window stage
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result item without a matching pixel");

endmodule

bind bayer_bilinear_demosaic_unit bbd_checker u_bbd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pix_in.valid),
  .in_ready   (pix_in.ready),
  .out_valid  (rgb_out.valid),
  .out_ready  (rgb_out.ready),
  .red_out    (rgb_out.red_out),
  .green_out  (rgb_out.green_out),
  .blue_out   (rgb_out.blue_out),
  .frame_last (rgb_out.frame_last)
);

// ----- verif/bayer_bilinear_demosaic_unit_tb.sv -----
// Self-checking testbench of the Bayer demosaic unit: mosaic frames in, checked RGB items out.
module bayer_bilinear_demosaic_unit_tb;
  import bbd_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int QUIET_LIMIT    = 4 * DEF_MAX_WIDTH;
  localparam int RANDOM_ITEMS   = 950;
  localparam int WIDE_ITEMS     = 200;
  localparam int MISMATCH_SHOWN = 10;
  localparam int IDLE_HEAVY     = 52;
  localparam int IDLE_LIGHT     = 13;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mix_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic             start;
  } pixel_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  bbd_pix_if pix ();
  bbd_rgb_if rgb ();

  bayer_bilinear_demosaic_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix),
    .rgb_out   (rgb)
  );

  // Own copy of the frame geometry, line stores, window and raster position
  int unsigned      row_len;
  int unsigned      frame_rows;
  logic [RAW_W-1:0] line_two_up [DEF_MAX_WIDTH];
  logic [RAW_W-1:0] line_one_up [DEF_MAX_WIDTH];
  logic [RAW_W-1:0] window_cols [6];
  int unsigned      next_col;
  int unsigned      next_row;

  pixel_t    pixel_backlog [$];
  result_t   pending_rgb [$];
  idle_mix_t idle_mix = IDLE_NONE;
  logic      pix_fire = 1'b0;
  int        errors = 0;
  int        pixels_taken = 0;
  int        results_checked = 0;
  int        frame_marks = 0;
  int        size_writes = 0;
  int        cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int idle_pct(input bit sender);
    case (idle_mix)
      IDLE_SENDER:   return sender ? IDLE_HEAVY : 0;
      IDLE_RECEIVER: return sender ? 0 : IDLE_HEAVY;
      IDLE_BOTH:     return IDLE_LIGHT;
      default:       return 0;
    endcase
  endfunction

  // Saturate a written size into 3..hi
  function automatic int unsigned fit_size(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Mostly random samples, with the extremes now and then
  function automatic logic [RAW_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return RAW_W'($urandom);
  endfunction

  // Place one pixel in the raster, emit the interpolated RGB of the centre it completes
  task automatic demosaic_pixel(input logic [RAW_W-1:0] raw, input logic start);
    int unsigned      cx;
    int unsigned      cy;
    int unsigned      x;
    int unsigned      y;
    int unsigned      wt;
    int unsigned      acc [3];
    logic [RAW_W-1:0] px;
    logic [RAW_W-1:0] above2;
    logic [RAW_W-1:0] above1;
    logic [RAW_W-1:0] tap [9];
    colour_t          colour;
    result_t          res;
    if (start) begin
      next_col = 0;
      next_row = 0;
    end
    // Fold counts left beyond a shrunken size back into the frame
    if (next_col >= row_len) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= frame_rows) next_row = 0;
    cx = next_col;
    cy = next_row;
    px = raw;
    // A trailing odd row or column carries no sample
    if (cx >= 2 * (row_len / 2) || cy >= 2 * (frame_rows / 2)) px = '0;
    above2 = line_two_up[cx];
    above1 = line_one_up[cx];

    if (cx >= 2 && cy >= 2) begin
      tap[0] = window_cols[0];
      tap[3] = window_cols[1];
      tap[6] = window_cols[2];
      tap[1] = window_cols[3];
      tap[4] = window_cols[4];
      tap[7] = window_cols[5];
      tap[2] = above2;
      tap[5] = above1;
      tap[8] = px;
      acc = '{0, 0, 0};
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          x = cx - 2 + c;
          y = cy - 2 + r;
          // GBRG: G/B on even rows, R/G on odd rows
          if ((y & 1) == 0) colour = ((x & 1) == 0) ? COL_GREEN : COL_BLUE;
          else              colour = ((x & 1) == 0) ? COL_RED : COL_GREEN;
          if (r == 1 && c == 1)      wt = 4;
          else if (r == 1 || c == 1) wt = (colour == COL_GREEN) ? 1 : 2;
          else                       wt = (colour == COL_GREEN) ? 0 : 1;
          acc[int'(colour)] += wt * tap[r * 3 + c];
        end
      end
      res.red   = RGB_W'(acc[int'(COL_RED)]);
      res.green = RGB_W'(acc[int'(COL_GREEN)]);
      res.blue  = RGB_W'(acc[int'(COL_BLUE)]);
      res.last  = (cx == row_len - 1) && (cy == frame_rows - 1);
      pending_rgb.push_back(res);
    end

    // Shift the window and update both line stores
    window_cols[0] = window_cols[3];
    window_cols[1] = window_cols[4];
    window_cols[2] = window_cols[5];
    window_cols[3] = above2;
    window_cols[4] = above1;
    window_cols[5] = px;
    line_two_up[cx] = above1;
    line_one_up[cx] = px;

    next_col = cx + 1;
    if (next_col >= row_len) begin
      next_col = 0;
      next_row = cy + 1;
      if (next_row >= frame_rows) next_row = 0;
    end
  endtask

  // Write one size register and track the saturated value
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_FRAME_WIDTH) row_len = fit_size(data, DEF_MAX_WIDTH);
    else                        frame_rows = fit_size(data, MAX_HEIGHT);
    size_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pixels(input int count, input bit marked, input int stray_pct);
    pixel_t p;
    for (int i = 0; i < count; i++) begin
      p.raw   = pick_sample();
      p.start = (i == 0) ? marked : chance(stray_pct);
      pixel_backlog.push_back(p);
    end
  endtask

  // Wait until every item is taken and every result is in, or progress stops, then let the pipeline settle
  task automatic wait_idle();
    int quiet;
    int seen;
    quiet = 0;
    seen  = -1;
    while (pixel_backlog.size() != 0 || pix.valid || pending_rgb.size() != 0) begin
      @(posedge clk);
      if (pixels_taken + results_checked != seen) begin
        seen  = pixels_taken + results_checked;
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet > QUIET_LIMIT) break;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: present the next pixel once the current one is taken
  always @(negedge clk) begin : drive_pixels
    pixel_t nxt;
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix_fire) begin
      if (pixel_backlog.size() != 0 && !chance(idle_pct(1'b1))) begin
        nxt = pixel_backlog.pop_front();
        pix.valid       <= 1'b1;
        pix.raw_sample  <= nxt.raw;
        pix.frame_start <= nxt.start;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    rgb.ready <= !rst && !chance(idle_pct(1'b0));
  end

  // Predict on every accepted pixel
  always @(posedge clk) begin : take_pixels
    pix_fire <= !rst && pix.valid && pix.ready;
    if (!rst && pix.valid && pix.ready) begin
      pixels_taken++;
      if (pix.frame_start) frame_marks++;
      demosaic_pixel(pix.raw_sample, pix.frame_start);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_rgb
    result_t got;
    result_t want;
    if (!rst && rgb.valid && rgb.ready) begin
      got.red   = rgb.red_out;
      got.green = rgb.green_out;
      got.blue  = rgb.blue_out;
      got.last  = rgb.frame_last;
      if (pending_rgb.size() == 0) begin
        errors++;
        if (errors <= MISMATCH_SHOWN)
          $display("unexpected result r=%0d g=%0d b=%0d last=%0b",
                   got.red, got.green, got.blue, got.last);
      end else begin
        want = pending_rgb.pop_front();
        results_checked++;
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.last !== want.last) begin
          errors++;
          if (errors <= MISMATCH_SHOWN)
            $display({"result %0d: expected r=%0d g=%0d b=%0d last=%0b,",
                      " got r=%0d g=%0d b=%0d last=%0b"},
                     results_checked, want.red, want.green, want.blue, want.last,
                     got.red, got.green, got.blue, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int     phase_no;
    int     random_items;
    int     frame_px;
    int     span;
    int     kind;
    pixel_t p;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_FRAME_WIDTH;
    cfg_data        = '0;
    pix.valid       = 1'b0;
    pix.raw_sample  = '0;
    pix.frame_start = 1'b0;
    rgb.ready       = 1'b0;

    // Reset state of the prediction
    row_len    = 32'(RST_FRAME_WIDTH);
    frame_rows = 32'(RST_FRAME_HEIGHT);
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      line_two_up[i] = '0;
      line_one_up[i] = '0;
    end
    for (int i = 0; i < 6; i++) window_cols[i] = '0;
    next_col = 0;
    next_row = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Smallest frame from sizes below range, all samples at full scale
    write_reg(REG_FRAME_WIDTH, SIZE_W'(0));
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(2));
    for (int i = 0; i < 9; i++) begin
      p.raw   = '1;
      p.start = (i == 0);
      pixel_backlog.push_back(p);
    end
    wait_idle();

    // Narrow frame, height above range: checkerboard of zero and full scale
    write_reg(REG_FRAME_WIDTH, SIZE_W'(4));
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(8191));
    for (int i = 0; i < 16; i++) begin
      p.raw   = (((i % 4) + (i / 4)) % 2 == 0) ? '1 : '0;
      p.start = (i == 0);
      pixel_backlog.push_back(p);
    end
    wait_idle();

    // Widest row, width above range, taken only a short way into the first line
    idle_mix = IDLE_BOTH;
    write_reg(REG_FRAME_WIDTH, SIZE_W'(4097));
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(3));
    queue_pixels(WIDE_ITEMS, 1'b1, 0);
    wait_idle();

    // Tallest frame, cut short
    idle_mix = IDLE_RECEIVER;
    write_reg(REG_FRAME_WIDTH, SIZE_W'(3));
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(4096));
    queue_pixels(3 * 40, 1'b1, 0);
    wait_idle();

    // Random phases: mostly whole frames, some unmarked, cut short or with stray markers
    phase_no     = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase_no++;
      idle_mix = idle_mix_t'(phase_no % 4);
      if (chance(85) || row_len > 16)
        write_reg(REG_FRAME_WIDTH,
                  SIZE_W'(chance(10) ? $urandom_range(0, 2) : $urandom_range(3, 12)));
      if (chance(85) || frame_rows > 16)
        write_reg(REG_FRAME_HEIGHT,
                  SIZE_W'(chance(10) ? $urandom_range(0, 2) : $urandom_range(3, 10)));
      repeat ($urandom_range(1, 3)) begin
        frame_px = row_len * frame_rows;
        kind     = $urandom_range(0, 99);
        if (kind < 70) begin
          span = frame_px;
          queue_pixels(span, 1'b1, 0);
        end else if (kind < 82) begin
          span = frame_px;
          queue_pixels(span, 1'b0, 0);
        end else if (kind < 92) begin
          span = $urandom_range(1, frame_px - 1);
          queue_pixels(span, 1'b1, 0);
        end else begin
          span = frame_px;
          queue_pixels(span, 1'($urandom_range(0, 1)), 3);
        end
        random_items += span;
      end
      wait_idle();
    end

    if (pending_rgb.size() != 0) begin
      errors += pending_rgb.size();
      $display("%0d expected results never arrived", pending_rgb.size());
    end
    $display("Streamed %0d pixels (%0d frame markers) over %0d size writes, %0d random phases.",
             pixels_taken, frame_marks, size_writes, phase_no);
    $display("Checked %0d RGB results, sides 3 to 4096, four idling mixes; %0d mismatches.",
             results_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bbd_pkg.sv
design/bbd_pix_if.sv
design/bbd_rgb_if.sv
design/bayer_bilinear_demosaic_unit.sv
design/bbd_checker.sv
verif/bayer_bilinear_demosaic_unit_tb.sv
